@@ rtl/lia_pkg.sv @@
package lia_pkg;

	localparam int LABEL_W  = 63;
	localparam int SLOT_W   = 8;

	// Operation carried by each request
	typedef enum logic [1:0] {
		FN_ALLOC        = 2'd0,
		FN_FREE         = 2'd1,
		FN_ID_OF_LABEL  = 2'd2,
		FN_LABEL_OF_ID  = 2'd3
	} func_t;

	// Outcome reported with each response
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_MISS    = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [SLOT_W-1:0]  slot_t;

endpackage

@@ rtl/lia_req_if.sv @@
interface lia_req_if import lia_pkg::*; ();
	logic   valid;
	logic   ready;
	func_t  func;
	label_t label;
	slot_t  slot_in;

	modport source (output valid, output func, output label, output slot_in, input ready);
	modport sink   (input valid, input func, input label, input slot_in, output ready);
endinterface

@@ rtl/lia_rsp_if.sv @@
interface lia_rsp_if import lia_pkg::*; ();
	logic    valid;
	logic    ready;
	slot_t   slot_out;
	label_t  label_out;
	status_t status;

	modport source (output valid, output slot_out, output label_out, output status, input ready);
	modport sink   (input valid, input slot_out, input label_out, input status, output ready);
endinterface

@@ rtl/lia_ram.sv @@
module lia_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/label_id_allocator_top.sv @@
// Label to slot id allocator. Requests are taken one at a time; the response sits in an
// output register, so a new request is accepted while the previous response waits.
// Labels live in a single-port-read label memory and are searched one entry per cycle,
// lowest slot first, which also finds the lowest free slot below the high-water mark.
// Allocate, free and id-of-label read the entries from slot 0 up to one past the
// matching slot on a hit, or up to the high-water mark on a miss, so at most CAPACITY;
// label-of-id reads the addressed slot. Slot valid bits are flip-flops cleared by reset,
// so no clearing pass is needed after reset. CAPACITY may range from 2 to 256.
module label_id_allocator_top import lia_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	lia_req_if.sink   req,
	lia_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int HW_W  = IDX_W + 1;
	localparam int CMP_W = (SLOT_W > HW_W) ? SLOT_W : HW_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [HW_W-1:0]    hw_q;
	logic [CAPACITY-1:0] valid_q;

	func_t              func_q;
	label_t             label_q;
	logic [HW_W-1:0]    ra_q;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic               rsp_vld_q;
	slot_t              rsp_slot_q;
	label_t             rsp_label_q;
	status_t            rsp_status_q;

	logic               acc;
	logic               lid_hit;
	logic               cmp_hit;
	logic               cmp_last;
	logic               rsp_load;

	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	label_t             ram_rdata;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;

	logic               set_valid;
	logic               clr_valid;
	logic               hw_inc;
	logic               hw_dec;
	slot_t              nxt_slot;
	label_t             nxt_label;
	status_t            nxt_status;

	lia_ram #(
		.WIDTH (LABEL_W),
		.DEPTH (CAPACITY)
	) u_label_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (label_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready     = (state_q == S_IDLE);
	assign acc           = req.valid && req.ready;
	assign rsp.valid     = rsp_vld_q;
	assign rsp.slot_out  = rsp_slot_q;
	assign rsp.label_out = rsp_label_q;
	assign rsp.status    = rsp_status_q;

	// Slot lookup hits only a valid slot below the mark
	assign lid_hit = (CMP_W'(req.slot_in) < CMP_W'(hw_q)) &&
	                 valid_q[req.slot_in[IDX_W-1:0]];

	// Compare the entry returned by the memory this cycle
	assign cmp_hit  = valid_q[cmp_idx_s1] && (ram_rdata == label_q);
	assign cmp_last = (HW_W'(cmp_idx_s1) == (hw_q - HW_W'(1)));

	// Result is taken into the output register once it is free
	assign rsp_load = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);

	// Issue label memory reads
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (acc) begin
			if (req.func == FN_LABEL_OF_ID) begin
				ram_re    = lid_hit;
				ram_raddr = req.slot_in[IDX_W-1:0];
			end else begin
				ram_re    = (hw_q != '0);
			end
		end else if (state_q == S_SCAN && ra_q < hw_q) begin
			ram_re    = 1'b1;
			ram_raddr = ra_q[IDX_W-1:0];
		end
	end

	// Work out the response and the state update
	always_comb begin
		nxt_slot   = '0;
		nxt_label  = '0;
		nxt_status = ST_MISS;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		hw_inc     = 1'b0;
		hw_dec     = 1'b0;
		case (func_q)
			FN_ALLOC: begin
				if (hit_q) begin
					nxt_slot   = SLOT_W'(hit_idx_q);
					nxt_status = ST_PRESENT;
				end else if (free_q) begin
					nxt_slot   = SLOT_W'(free_idx_q);
					nxt_status = ST_OK;
					ram_we     = rsp_load;
					ram_waddr  = free_idx_q;
					set_valid  = rsp_load;
				end else if (hw_q < HW_W'(CAPACITY)) begin
					nxt_slot   = SLOT_W'(hw_q);
					nxt_status = ST_OK;
					ram_we     = rsp_load;
					ram_waddr  = hw_q[IDX_W-1:0];
					set_valid  = rsp_load;
					hw_inc     = rsp_load;
				end else begin
					nxt_status = ST_FULL;
				end
			end
			FN_FREE: begin
				if (hit_q) begin
					nxt_slot   = SLOT_W'(hit_idx_q);
					nxt_status = ST_OK;
					clr_valid  = rsp_load;
					hw_dec     = rsp_load &&
					             ((HW_W'(hit_idx_q) + HW_W'(1)) == hw_q);
				end
			end
			FN_ID_OF_LABEL: begin
				if (hit_q) begin
					nxt_slot   = SLOT_W'(hit_idx_q);
					nxt_label  = label_q;
					nxt_status = ST_OK;
				end
			end
			FN_LABEL_OF_ID: begin
				if (hit_q) begin
					nxt_slot   = SLOT_W'(hit_idx_q);
					nxt_label  = ram_rdata;
					nxt_status = ST_OK;
				end
			end
			default: begin
				nxt_status = ST_MISS;
			end
		endcase
	end

	// Sequencer, high-water mark, valid bits and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			hw_q      <= '0;
			valid_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (req.func == FN_LABEL_OF_ID || hw_q == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cmp_hit || cmp_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (set_valid) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (hw_inc) begin
				hw_q <= hw_q + HW_W'(1);
			end else if (hw_dec) begin
				hw_q <= hw_q - HW_W'(1);
			end

			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Capture the request and track the scan
	always_ff @(posedge clk) begin
		if (acc) begin
			func_q     <= req.func;
			label_q    <= req.label;
			free_q     <= 1'b0;
			ra_q       <= HW_W'(1);
			cmp_idx_s1 <= '0;
			if (req.func == FN_LABEL_OF_ID) begin
				hit_q     <= lid_hit;
				hit_idx_q <= req.slot_in[IDX_W-1:0];
			end else begin
				hit_q     <= 1'b0;
			end
		end else if (state_q == S_SCAN) begin
			if (ram_re) begin
				ra_q       <= ra_q + HW_W'(1);
				cmp_idx_s1 <= ra_q[IDX_W-1:0];
			end
			if (cmp_hit) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
			end else if (!valid_q[cmp_idx_s1] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	// Hold the response payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_slot_q   <= nxt_slot;
			rsp_label_q  <= nxt_label;
			rsp_status_q <= nxt_status;
		end
	end

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= HW_W'(CAPACITY))
		else $error("high-water mark beyond capacity");

	a_scan_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (HW_W'(cmp_idx_s1) < hw_q))
		else $error("scan compares an entry at or above the mark");

	a_write_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_DONE))
		else $error("label memory written outside response stage");

	a_full_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && nxt_status == ST_FULL) |-> (hw_q == HW_W'(CAPACITY) && !free_q))
		else $error("full reported with room left");

endmodule

@@ test/tb_top.sv @@
module tb_top import lia_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TB_CAP      = 256;
	localparam int DRAIN_CYC   = 300;
	localparam int POOL_MAX    = 200;
	localparam label_t LBL_MAX = '1;

	typedef struct packed {
		func_t  func;
		label_t label;
		slot_t  slot_in;
		logic   hold;
	} req_item_t;

	typedef struct packed {
		slot_t   slot_out;
		label_t  label_out;
		status_t status;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n;

	lia_req_if req_ch ();
	lia_rsp_if rsp_ch ();

	label_id_allocator_top #(
		.CAPACITY(TB_CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	// Shadow copy of the slot table
	label_t     shadow_label [TB_CAP];
	logic       shadow_valid [TB_CAP];
	int         shadow_mark;

	req_item_t  req_pending_q [$];
	rsp_item_t  rsp_expect_q [$];
	label_t     label_pool [$];
	req_item_t  cur_req;
	rsp_item_t  got_rsp;
	rsp_item_t  want_rsp;
	logic       took;
	int         n_total;
	int         n_accepted;
	int         n_retired;
	int         n_fail;
	int         idle_phase;
	int         send_idle_pct;
	int         recv_idle_pct;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Lowest valid slot holding the label, or -1
	function automatic int shadow_find(label_t lbl);
		int hit;
		hit = -1;
		for (int i = 0; i < shadow_mark; i++)
			if (hit < 0 && shadow_valid[i] && shadow_label[i] == lbl)
				hit = i;
		return hit;
	endfunction

	// Apply one request to the shadow table and return the response it should give
	function automatic rsp_item_t slot_table_apply(req_item_t it);
		rsp_item_t r;
		int hit;
		int spare;
		r.slot_out  = '0;
		r.label_out = '0;
		r.status    = ST_MISS;
		hit = shadow_find(it.label);
		case (it.func)
			FN_ALLOC: begin
				if (hit >= 0) begin
					r.slot_out = slot_t'(hit);
					r.status   = ST_PRESENT;
				end else begin
					spare = -1;
					for (int i = 0; i < shadow_mark; i++)
						if (spare < 0 && !shadow_valid[i])
							spare = i;
					if (spare < 0 && shadow_mark < TB_CAP) begin
						spare = shadow_mark;
						shadow_mark++;
					end
					if (spare < 0) begin
						r.status = ST_FULL;
					end else begin
						shadow_valid[spare] = 1'b1;
						shadow_label[spare] = it.label;
						r.slot_out = slot_t'(spare);
						r.status   = ST_OK;
					end
				end
			end
			FN_FREE: begin
				if (hit >= 0) begin
					shadow_valid[hit] = 1'b0;
					// only the topmost slot pulls the mark down
					if (hit + 1 == shadow_mark)
						shadow_mark--;
					r.slot_out = slot_t'(hit);
					r.status   = ST_OK;
				end
			end
			FN_ID_OF_LABEL: begin
				if (hit >= 0) begin
					r.slot_out  = slot_t'(hit);
					r.label_out = it.label;
					r.status    = ST_OK;
				end
			end
			default: begin
				if (int'(it.slot_in) < shadow_mark && shadow_valid[it.slot_in]) begin
					r.slot_out  = it.slot_in;
					r.label_out = shadow_label[it.slot_in];
					r.status    = ST_OK;
				end
			end
		endcase
		return r;
	endfunction

	function automatic label_t fresh_label();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return LBL_MAX;
			2:       return label_t'($urandom_range(0, 15));
			default: return w[LABEL_W-1:0];
		endcase
	endfunction

	// Mostly reuse known labels so that hits happen; remember new ones used for allocation requests
	function automatic label_t pick_label(bit is_alloc);
		label_t l;
		if (label_pool.size() != 0 && $urandom_range(0, 99) < 75) begin
			l = label_pool[$urandom_range(0, label_pool.size() - 1)];
		end else begin
			l = fresh_label();
			if (is_alloc) begin
				label_pool = {label_pool, l};
				if (label_pool.size() > POOL_MAX)
					void'(label_pool.pop_front());
			end
		end
		return l;
	endfunction

	task automatic queue_req(func_t f, label_t l, slot_t s, logic h);
		req_item_t it;
		it.func    = f;
		it.label   = l;
		it.slot_in = s;
		it.hold    = h;
		req_pending_q = {req_pending_q, it};
	endtask

	task automatic queue_mixed();
		int pick;
		func_t f;
		slot_t s;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			f = FN_ALLOC;
		else if (pick < 60)
			f = FN_FREE;
		else if (pick < 80)
			f = FN_ID_OF_LABEL;
		else
			f = FN_LABEL_OF_ID;
		if ($urandom_range(0, 3) == 0)
			s = slot_t'($urandom());
		else
			s = slot_t'($urandom_range(0, 47));
		queue_req(f, pick_label(f == FN_ALLOC), s, $urandom_range(0, 99) == 0);
	endtask

	// Build the request list, release reset, then wait for the drain
	initial begin
		label_t la;
		label_t lb;
		label_t l;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.func    = FN_ALLOC;
		req_ch.label   = '0;
		req_ch.slot_in = '0;
		rsp_ch.ready   = 1'b0;
		n_fail         = 0;
		n_accepted     = 0;
		shadow_mark    = 0;
		for (int i = 0; i < TB_CAP; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_label[i] = '0;
		end
		la = 63'h2AAA_AAAA_AAAA_AAAA;
		lb = 63'h5555_5555_5555_5555;

		// Directed: extremes, reuse of a freed slot, lowering of the mark
		queue_req(FN_ALLOC,       '0,      '0,       1'b0);
		queue_req(FN_ALLOC,       LBL_MAX, '0,       1'b0);
		queue_req(FN_ALLOC,       '0,      '0,       1'b0);
		queue_req(FN_ID_OF_LABEL, LBL_MAX, '0,       1'b0);
		queue_req(FN_LABEL_OF_ID, la,      8'd0,     1'b0);
		queue_req(FN_LABEL_OF_ID, '0,      8'd255,   1'b0);
		queue_req(FN_LABEL_OF_ID, '0,      8'd2,     1'b0);
		queue_req(FN_FREE,        la,      '0,       1'b0);
		queue_req(FN_ID_OF_LABEL, la,      '0,       1'b0);
		queue_req(FN_ALLOC,       la,      '1,       1'b1);
		queue_req(FN_FREE,        '0,      '0,       1'b0);
		queue_req(FN_LABEL_OF_ID, '0,      8'd0,     1'b0);
		queue_req(FN_ALLOC,       lb,      '0,       1'b0);
		queue_req(FN_FREE,        la,      '0,       1'b0);
		queue_req(FN_LABEL_OF_ID, '0,      8'd2,     1'b0);
		queue_req(FN_ALLOC,       la,      '0,       1'b0);
		queue_req(FN_FREE,        LBL_MAX, '0,       1'b0);
		queue_req(FN_FREE,        lb,      '0,       1'b0);
		queue_req(FN_ALLOC,       LBL_MAX, '0,       1'b0);
		queue_req(FN_LABEL_OF_ID, '0,      8'd1,     1'b0);
		queue_req(FN_ID_OF_LABEL, '0,      '0,       1'b0);
		queue_req(FN_FREE,        la,      '0,       1'b0);
		queue_req(FN_FREE,        LBL_MAX, '0,       1'b0);

		// Random: mixed traffic, a fill past capacity, a free sweep, more mixed traffic
		for (int i = 0; i < 200; i++)
			queue_mixed();
		for (int i = 0; i < TB_CAP + 6; i++) begin
			l = fresh_label();
			label_pool = {label_pool, l};
			if (label_pool.size() > POOL_MAX)
				void'(label_pool.pop_front());
			queue_req(FN_ALLOC, l, slot_t'($urandom()), i == 0);
		end
		for (int i = 0; i < 10; i++) begin
			queue_req(FN_ALLOC, fresh_label(), '0, 1'b0);
			queue_req(FN_LABEL_OF_ID, '0, slot_t'($urandom()), 1'b0);
		end
		for (int i = 0; i < 120; i++) begin
			if ($urandom_range(0, 4) == 0)
				queue_req(FN_ID_OF_LABEL, pick_label(1'b0), '0, 1'b0);
			else
				queue_req(FN_FREE, pick_label(1'b0), slot_t'($urandom()), 1'b0);
		end
		for (int i = 0; i < 60; i++)
			queue_mixed();
		n_total = req_pending_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted != n_total || n_retired != n_accepted)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (rsp_expect_q.size() != 0) begin
			$display("%0t: %0d expected responses never arrived", $time, rsp_expect_q.size());
			n_fail = n_fail + 1;
		end
		if (n_fail == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("%0t: timeout", $time);
		$display("Test completed with failures");
		$finish;
	end

	// Pick the idling split from progress through the request list
	always_comb begin
		case (idle_phase)
			0:       begin send_idle_pct = 25; recv_idle_pct = 87; end
			1:       begin send_idle_pct = 87; recv_idle_pct = 25; end
			default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
		endcase
	end

	// Request driver: predict on each transfer, hold valid until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.func    <= FN_ALLOC;
			req_ch.label   <= '0;
			req_ch.slot_in <= '0;
			idle_phase     <= 0;
		end else begin
			took = req_ch.valid && req_ch.ready;
			if (took) begin
				rsp_expect_q = {rsp_expect_q, slot_table_apply(cur_req)};
				n_accepted = n_accepted + 1;
			end
			idle_phase <= (n_accepted < n_total / 3) ? 0 :
				(n_accepted < (2 * n_total) / 3) ? 1 : 2;
			if (!req_ch.valid || took) begin
				if (req_pending_q.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct &&
						!(req_pending_q[0].hold && (took || n_accepted != n_retired))) begin
					cur_req = req_pending_q.pop_front();
					req_ch.valid   <= 1'b1;
					req_ch.func    <= cur_req.func;
					req_ch.label   <= cur_req.label;
					req_ch.slot_in <= cur_req.slot_in;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compare each transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			n_retired    <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_retired <= n_retired + 1;
				got_rsp.slot_out  = rsp_ch.slot_out;
				got_rsp.label_out = rsp_ch.label_out;
				got_rsp.status    = rsp_ch.status;
				if (rsp_expect_q.size() == 0) begin
					$display("%0t: unexpected response slot %0d label %h status %0d", $time,
						got_rsp.slot_out, got_rsp.label_out, got_rsp.status);
					n_fail = n_fail + 1;
				end else begin
					want_rsp = rsp_expect_q.pop_front();
					if (got_rsp.slot_out !== want_rsp.slot_out) begin
						$display("%0t: slot_out expected %0d got %0d", $time,
							want_rsp.slot_out, got_rsp.slot_out);
						n_fail = n_fail + 1;
					end
					if (got_rsp.label_out !== want_rsp.label_out) begin
						$display("%0t: label_out expected %h got %h", $time,
							want_rsp.label_out, got_rsp.label_out);
						n_fail = n_fail + 1;
					end
					if (got_rsp.status !== want_rsp.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							want_rsp.status, got_rsp.status);
						n_fail = n_fail + 1;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

endmodule
